// ===== sv/ple_pkg.sv =====
// Package: request/result types, action and status codes, controller commands.
package ple_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CNT_W = 7;
	localparam int VAL_W = 32;
	localparam int WIDE_W = 64;

	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_POS   = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_BACK  = 3'd4,
		ACT_DEL_POS   = 3'd5,
		ACT_DUMP      = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_BADPOS = 2'd1,
		STS_FULL   = 2'd2,
		STS_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_DEL,
		OP_ROT
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic [2:0]              action;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [CNT_W-1:0]        count;
		logic signed [VAL_W-1:0] element;
		logic                    element_valid;
		logic                    last;
	} res_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] idx;
		logic             res_load;
		status_t          status;
		logic             elem_sel;
		logic             last;
	} ple_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] len;
		logic             res_busy;
	} ple_sts_t;

endpackage

// ===== sv/ple_dpath.sv =====
// Datapath: shifting cell row, length register and result register.
module ple_dpath #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic signed [31:0] value,
	input  ple_pkg::ple_cmd_t cmd,
	input  logic              res_ready,
	output ple_pkg::ple_sts_t sts,
	output logic              res_valid,
	output ple_pkg::res_t     res
);
	import ple_pkg::*;

	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      len_d;
	logic                  res_valid_q;
	res_t                  res_q;
	logic signed [WIDE_W-1:0] val_wide;
	logic signed [WIDE_W-1:0] head_wide;
	logic [DATA_WIDTH-1:0] word;

	assign val_wide  = WIDE_W'(value);
	assign word      = val_wide[DATA_WIDTH-1:0];
	assign head_wide = WIDE_W'(signed'(cell_q[0]));

	always_comb begin
		case (cmd.op)
			OP_INS:  len_d = len_q + CNT_W'(1);
			OP_DEL:  len_d = len_q - CNT_W'(1);
			default: len_d = len_q;
		endcase
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
		localparam int PRV = (g == 0) ? 0 : g - 1;
		localparam int NXT = (g == DEPTH - 1) ? g : g + 1;

		always_ff @(posedge clk) begin
			case (cmd.op)
				OP_INS: begin
					if (IDX == cmd.idx) begin
						cell_q[g] <= word;
					end else if (IDX > cmd.idx) begin
						cell_q[g] <= cell_q[PRV];
					end
				end
				OP_DEL: begin
					if (IDX >= cmd.idx) begin
						cell_q[g] <= cell_q[NXT];
					end
				end
				OP_ROT: begin
					if (IDX == len_q - CNT_W'(1)) begin
						cell_q[g] <= cell_q[0];
					end else begin
						cell_q[g] <= cell_q[NXT];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			len_q <= len_d;
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.status        <= cmd.status;
			res_q.count         <= len_d;
			res_q.element       <= cmd.elem_sel ? head_wide[VAL_W-1:0] : '0;
			res_q.element_valid <= cmd.elem_sel;
			res_q.last          <= cmd.last;
		end
	end

	assign sts.len      = len_q;
	assign sts.res_busy = res_valid_q;
	assign res_valid    = res_valid_q;
	assign res          = res_q;

endmodule

// ===== sv/ple_ctrl.sv =====
// Controller: request decode, range checks and dump sequencing.
module ple_ctrl #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [2:0]        action,
	input  logic [6:0]        position,
	input  logic              res_ready,
	input  ple_pkg::ple_sts_t sts,
	output ple_pkg::ple_cmd_t cmd
);
	import ple_pkg::*;

	localparam logic [CNT_W-1:0] FULL_LEN = CNT_W'(DEPTH);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] k_q;
	logic             slot_free;
	logic             fire;
	logic             full;
	logic             empty;
	logic             dump_last;
	logic [CNT_W:0]   pos_x;
	logic [CNT_W:0]   len_x;

	assign slot_free = !sts.res_busy || res_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign full      = (sts.len == FULL_LEN);
	assign empty     = (sts.len == '0);
	assign dump_last = (k_q == sts.len - CNT_W'(1));
	assign pos_x     = {1'b0, position};
	assign len_x     = {1'b0, sts.len};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire && action == ACT_DUMP && !empty) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (slot_free && dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready    = 1'b0;
		cmd.op       = OP_NONE;
		cmd.idx      = '0;
		cmd.res_load = 1'b0;
		cmd.status   = STS_OK;
		cmd.elem_sel = 1'b0;
		cmd.last     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = slot_free;
				if (fire) begin
					cmd.res_load = 1'b1;
					unique case (action_t'(action)) inside
						ACT_INS_FRONT, ACT_INS_BACK: begin
							cmd.idx = (action == ACT_INS_FRONT) ? '0 : sts.len;
							if (full) cmd.status = STS_FULL;
							else cmd.op = OP_INS;
						end
						ACT_INS_POS: begin
							cmd.idx = position - CNT_W'(1);
							if (position == '0 || pos_x > len_x + (CNT_W+1)'(1)) begin
								cmd.status = STS_BADPOS;
							end else if (full) begin
								cmd.status = STS_FULL;
							end else begin
								cmd.op = OP_INS;
							end
						end
						ACT_DEL_FRONT, ACT_DEL_BACK: begin
							cmd.idx = (action == ACT_DEL_FRONT) ? '0 : sts.len - CNT_W'(1);
							if (empty) cmd.status = STS_EMPTY;
							else cmd.op = OP_DEL;
						end
						ACT_DEL_POS: begin
							cmd.idx = position - CNT_W'(1);
							if (empty) begin
								cmd.status = STS_EMPTY;
							end else if (position == '0 || pos_x > len_x) begin
								cmd.status = STS_BADPOS;
							end else begin
								cmd.op = OP_DEL;
							end
						end
						ACT_DUMP: begin
							cmd.res_load = empty;
						end
						default: ;
					endcase
				end
			end
			ST_DUMP: begin
				if (slot_free) begin
					cmd.op       = OP_ROT;
					cmd.res_load = 1'b1;
					cmd.elem_sel = 1'b1;
					cmd.last     = dump_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				k_q <= '0;
			end else if (slot_free) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/positional_list_engine_core.sv =====
// Top level: bounded positional list, controller plus cell-row datapath.
//
//   channel  | signals                      | moves
//   ---------+------------------------------+----------------------------------
//   request  | cmd_valid, cmd_ready, cmd    | action, value, position
//   result   | res_valid, res_ready, res    | status, count, element, valid, last
//
// An edit shifts all affected cells at once and registers one result.
// A dump first takes the request; then the cell row rotates by one per cycle
// while the result register is free, and the front cell feeds that register.
// An empty dump registers its result as the request is taken.
// Outside a dump, a request is taken if the result register is empty or draining.
// Reset clears the length, the result valid flag and the controller; cells
// keep their contents.
module positional_list_engine_core #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ple_pkg::req_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output ple_pkg::res_t  res
);
	import ple_pkg::*;

	ple_cmd_t ctl;
	ple_sts_t sts;

	ple_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.action   (cmd.action),
		.position (cmd.position),
		.res_ready(res_ready),
		.sts      (sts),
		.cmd      (ctl)
	);

	ple_dpath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (cmd.value),
		.cmd      (ctl),
		.res_ready(res_ready),
		.sts      (sts),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

// ===== sv/ple_checker.sv =====
// Checker on the top-level ports, bound to the core.
module ple_checker #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input ple_pkg::res_t res
);
	import ple_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.count <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.element_valid |-> res.status == STS_OK)
		else $error("dump element with error status");

	a_edit_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.element_valid |-> res.last && res.element == '0)
		else $error("non-element result not last or nonzero");

endmodule

bind positional_list_engine_core ple_checker #(.DEPTH(DEPTH)) u_ple_checker (.*);
